### hdl/msah_pkg.sv
package msah_pkg;

  localparam int unsigned XLEN = 64;
  localparam int unsigned HLEN = 32;
  // step counter: counts XLEN division steps, 0 to XLEN - 1
  localparam int unsigned CNT_W = $clog2(XLEN + 1);

  // SPECIAL funct codes
  localparam logic [5:0] F_SLL     = 6'd0;
  localparam logic [5:0] F_SRL     = 6'd2;
  localparam logic [5:0] F_SRA     = 6'd3;
  localparam logic [5:0] F_SLLV    = 6'd4;
  localparam logic [5:0] F_SRLV    = 6'd6;
  localparam logic [5:0] F_SRAV    = 6'd7;
  localparam logic [5:0] F_SYSCALL = 6'd12;
  localparam logic [5:0] F_MFHI    = 6'd16;
  localparam logic [5:0] F_MTHI    = 6'd17;
  localparam logic [5:0] F_MFLO    = 6'd18;
  localparam logic [5:0] F_MTLO    = 6'd19;
  localparam logic [5:0] F_DSLLV   = 6'd20;
  localparam logic [5:0] F_DSRLV   = 6'd22;
  localparam logic [5:0] F_DSRAV   = 6'd23;
  localparam logic [5:0] F_MULT    = 6'd24;
  localparam logic [5:0] F_MULTU   = 6'd25;
  localparam logic [5:0] F_DIV     = 6'd26;
  localparam logic [5:0] F_DIVU    = 6'd27;
  localparam logic [5:0] F_DMULT   = 6'd28;
  localparam logic [5:0] F_DMULTU  = 6'd29;
  localparam logic [5:0] F_DDIV    = 6'd30;
  localparam logic [5:0] F_DDIVU   = 6'd31;
  localparam logic [5:0] F_ADD     = 6'd32;
  localparam logic [5:0] F_ADDU    = 6'd33;
  localparam logic [5:0] F_SUB     = 6'd34;
  localparam logic [5:0] F_SUBU    = 6'd35;
  localparam logic [5:0] F_AND     = 6'd36;
  localparam logic [5:0] F_OR      = 6'd37;
  localparam logic [5:0] F_XOR     = 6'd38;
  localparam logic [5:0] F_NOR     = 6'd39;
  localparam logic [5:0] F_SLT     = 6'd42;
  localparam logic [5:0] F_SLTU    = 6'd43;
  localparam logic [5:0] F_DADD    = 6'd44;
  localparam logic [5:0] F_DADDU   = 6'd45;
  localparam logic [5:0] F_DSUB    = 6'd46;
  localparam logic [5:0] F_DSUBU   = 6'd47;
  localparam logic [5:0] F_TEQ     = 6'd52;
  localparam logic [5:0] F_DSLL    = 6'd56;
  localparam logic [5:0] F_DSRL    = 6'd58;
  localparam logic [5:0] F_DSRA    = 6'd59;
  localparam logic [5:0] F_DSLL32  = 6'd60;
  localparam logic [5:0] F_DSRL32  = 6'd62;
  localparam logic [5:0] F_DSRA32  = 6'd63;

  localparam logic [1:0] TRAP_NONE = 2'd0;
  localparam logic [1:0] TRAP_SYS  = 2'd1;
  localparam logic [1:0] TRAP_TEQ  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_DIV, ST_FIX, ST_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture operands, do ALU and HI/LO move ops
    logic mul_step;  // one partial product
    logic div_step;  // one restoring-division bit
    logic fix;       // sign fix and HI/LO write-back
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_mul;
    logic is_div;
    logic last;
  } sts_t;

endpackage

### hdl/msah_ctrl.sv
module msah_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output msah_pkg::cmd_t  cmd_o,
  input  msah_pkg::sts_t  sts_i
);

  msah_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= msah_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      msah_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = msah_pkg::ST_OUT;
        end
      end
      msah_pkg::ST_OUT: begin
        if (out_ready_i) begin
          if (sts_i.is_mul) begin
            state_d = msah_pkg::ST_MUL;
          end else if (sts_i.is_div) begin
            state_d = msah_pkg::ST_DIV;
          end else begin
            state_d = msah_pkg::ST_IDLE;
          end
        end
      end
      msah_pkg::ST_MUL: begin
        if (sts_i.last) begin
          state_d = msah_pkg::ST_FIX;
        end
      end
      msah_pkg::ST_DIV: begin
        if (sts_i.last) begin
          state_d = msah_pkg::ST_FIX;
        end
      end
      msah_pkg::ST_FIX: state_d = msah_pkg::ST_IDLE;
      default: state_d = msah_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    out_valid_o    = 1'b0;
    cmd_o          = '0;
    case (state_q)
      msah_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      msah_pkg::ST_OUT: out_valid_o = 1'b1;
      msah_pkg::ST_MUL: cmd_o.mul_step = 1'b1;
      msah_pkg::ST_DIV: cmd_o.div_step = 1'b1;
      msah_pkg::ST_FIX: begin
        cmd_o.fix   = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

### hdl/msah_dp.sv
module msah_dp (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [5:0]               command_i,
  input  logic signed [63:0]       rs_value_i,
  input  logic signed [63:0]       rt_value_i,
  input  logic [4:0]               shift_amount_i,
  input  msah_pkg::cmd_t           cmd_i,
  output msah_pkg::sts_t           sts_o,
  output logic signed [63:0]       rd_value_o,
  output logic                     rd_write_o,
  output logic [1:0]               trap_code_o
);

  logic [63:0]  hi_q, lo_q;
  logic [63:0]  a_q, b_q;          // magnitudes / operands
  logic [127:0] acc_q;             // product, or {rem,quot} during division
  logic [msah_pkg::CNT_W-1:0] cnt_q;
  logic         neg_q, negr_q, zero_q, w32_q;
  logic         is_mul_q, is_div_q;
  logic [63:0]  rd_q;
  logic         wr_q;
  logic [1:0]   trap_q;

  // combinational ALU result
  logic [31:0] rs32, rt32, r32;
  logic [63:0] r64;
  logic        wr;
  logic [1:0]  trap;
  logic [4:0]  sh5;
  logic [5:0]  sh6;
  logic        mul_op, div_op, sgn, w32;
  logic [63:0] oa, ob, ma, mb;

  function automatic logic [63:0] sx(input logic [31:0] x);
    sx = {{32{x[31]}}, x};
  endfunction

  always_comb begin
    rs32 = rs_value_i[31:0];
    rt32 = rt_value_i[31:0];
    r32  = '0;
    r64  = '0;
    wr   = 1'b1;
    trap = msah_pkg::TRAP_NONE;
    sh5  = rs32[4:0];
    sh6  = rs32[5:0];
    case (command_i)
      msah_pkg::F_SLL:   r64 = sx(rt32 << shift_amount_i);
      msah_pkg::F_SRL:   r64 = sx(rt32 >> shift_amount_i);
      msah_pkg::F_SRA:   r64 = sx(32'($signed(rt32) >>> shift_amount_i));
      msah_pkg::F_SLLV:  r64 = sx(rt32 << sh5);
      msah_pkg::F_SRLV:  r64 = sx(rt32 >> sh5);
      msah_pkg::F_SRAV:  r64 = sx(32'($signed(rt32) >>> sh5));
      msah_pkg::F_SYSCALL: begin wr = 1'b0; trap = msah_pkg::TRAP_SYS; end
      msah_pkg::F_MFHI:  r64 = hi_q;
      msah_pkg::F_MFLO:  r64 = lo_q;
      msah_pkg::F_DSLLV: r64 = rt_value_i << sh6;
      msah_pkg::F_DSRLV: r64 = rt_value_i >> sh6;
      msah_pkg::F_DSRAV: r64 = 64'(rt_value_i >>> sh6);
      msah_pkg::F_ADD, msah_pkg::F_ADDU: begin
        r32 = rs32 + rt32;
        r64 = sx(r32);
      end
      msah_pkg::F_SUB, msah_pkg::F_SUBU: begin
        r32 = rs32 - rt32;
        r64 = sx(r32);
      end
      msah_pkg::F_AND:   r64 = rs_value_i & rt_value_i;
      msah_pkg::F_OR:    r64 = rs_value_i | rt_value_i;
      msah_pkg::F_XOR:   r64 = rs_value_i ^ rt_value_i;
      msah_pkg::F_NOR:   r64 = ~(rs_value_i | rt_value_i);
      msah_pkg::F_SLT:   r64 = {63'd0, rs_value_i < rt_value_i};
      msah_pkg::F_SLTU:  r64 = {63'd0, $unsigned(rs_value_i) < $unsigned(rt_value_i)};
      msah_pkg::F_DADD, msah_pkg::F_DADDU: r64 = rs_value_i + rt_value_i;
      msah_pkg::F_DSUB, msah_pkg::F_DSUBU: r64 = rs_value_i - rt_value_i;
      msah_pkg::F_TEQ: begin
        wr = 1'b0;
        if (rs_value_i == rt_value_i) trap = msah_pkg::TRAP_TEQ;
      end
      msah_pkg::F_DSLL:   r64 = rt_value_i << shift_amount_i;
      msah_pkg::F_DSRL:   r64 = rt_value_i >> shift_amount_i;
      msah_pkg::F_DSRA:   r64 = 64'(rt_value_i >>> shift_amount_i);
      msah_pkg::F_DSLL32: r64 = rt_value_i << {1'b1, shift_amount_i};
      msah_pkg::F_DSRL32: r64 = rt_value_i >> {1'b1, shift_amount_i};
      msah_pkg::F_DSRA32: r64 = 64'(rt_value_i >>> {1'b1, shift_amount_i});
      default: wr = 1'b0;
    endcase
    if (!wr) r64 = '0;
  end

  // multiply/divide decode and operand magnitudes
  always_comb begin
    mul_op = (command_i == msah_pkg::F_MULT) || (command_i == msah_pkg::F_MULTU) ||
             (command_i == msah_pkg::F_DMULT) || (command_i == msah_pkg::F_DMULTU);
    div_op = (command_i == msah_pkg::F_DIV) || (command_i == msah_pkg::F_DIVU) ||
             (command_i == msah_pkg::F_DDIV) || (command_i == msah_pkg::F_DDIVU);
    sgn = (command_i == msah_pkg::F_MULT) || (command_i == msah_pkg::F_DMULT) ||
          (command_i == msah_pkg::F_DIV) || (command_i == msah_pkg::F_DDIV);
    w32 = (command_i == msah_pkg::F_MULT) || (command_i == msah_pkg::F_MULTU) ||
          (command_i == msah_pkg::F_DIV) || (command_i == msah_pkg::F_DIVU);
    if (w32) begin
      oa = sgn ? sx(rs_value_i[31:0]) : {32'd0, rs_value_i[31:0]};
      ob = sgn ? sx(rt_value_i[31:0]) : {32'd0, rt_value_i[31:0]};
    end else begin
      oa = rs_value_i;
      ob = rt_value_i;
    end
    ma = (sgn && oa[63]) ? 64'(-oa) : oa;
    mb = (sgn && ob[63]) ? 64'(-ob) : ob;
  end

  // one 64x16 partial product a cycle over the four 16-bit slices of b; one quotient bit a cycle
  logic [79:0]  pp;
  logic [64:0]  trial;
  logic [127:0] sh;
  logic [127:0] negp;
  logic [63:0]  q_fix, r_fix;

  always_comb begin
    pp    = a_q * b_q[15:0];
    sh    = {acc_q[126:0], 1'b0};
    trial = {1'b0, sh[127:64]} - {1'b0, b_q};
    negp  = 128'(-acc_q);
    q_fix = neg_q  ? 64'(-acc_q[63:0])   : acc_q[63:0];
    r_fix = negr_q ? 64'(-acc_q[127:64]) : acc_q[127:64];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_q     <= '0;
      lo_q     <= '0;
      is_mul_q <= 1'b0;
      is_div_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (cmd_i.load) begin
        is_mul_q <= mul_op;
        is_div_q <= div_op;
        cnt_q    <= '0;
        if (command_i == msah_pkg::F_MTHI) hi_q <= rs_value_i;
        if (command_i == msah_pkg::F_MTLO) lo_q <= rs_value_i;
      end else if (cmd_i.mul_step || cmd_i.div_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.fix) begin
        is_mul_q <= 1'b0;
        is_div_q <= 1'b0;
        if (is_mul_q) begin
          if (w32_q) begin
            hi_q <= sx(negp[63:32] & {32{neg_q}} | acc_q[63:32] & {32{!neg_q}});
            lo_q <= sx(neg_q ? negp[31:0] : acc_q[31:0]);
          end else begin
            hi_q <= neg_q ? negp[127:64] : acc_q[127:64];
            lo_q <= neg_q ? negp[63:0]   : acc_q[63:0];
          end
        end else if (!zero_q) begin
          if (w32_q) begin
            hi_q <= sx(r_fix[31:0]);
            lo_q <= sx(q_fix[31:0]);
          end else begin
            hi_q <= r_fix;
            lo_q <= q_fix;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q    <= ma;
      b_q    <= mb;
      w32_q  <= w32;
      neg_q  <= sgn && (oa[63] ^ ob[63]);
      negr_q <= sgn && oa[63];
      zero_q <= (ob == 64'd0);
      acc_q  <= div_op ? {64'd0, ma} : '0;
      rd_q   <= r64;
      wr_q   <= wr;
      trap_q <= trap;
    end else if (cmd_i.mul_step) begin
      acc_q <= acc_q + (128'(pp) << {cnt_q[1:0], 4'd0});
      b_q   <= b_q >> 16;
    end else if (cmd_i.div_step) begin
      if (!trial[64]) acc_q <= {trial[63:0], sh[63:1], 1'b1};
      else            acc_q <= sh;
    end
  end

  assign sts_o.is_mul = is_mul_q;
  assign sts_o.is_div = is_div_q;
  assign sts_o.last   = is_mul_q ? (cnt_q == msah_pkg::CNT_W'(3)) :
                                   (cnt_q == msah_pkg::CNT_W'(msah_pkg::XLEN - 1));

  assign rd_value_o  = rd_q;
  assign rd_write_o  = wr_q;
  assign trap_code_o = trap_q;

endmodule

### hdl/mips64_special_alu_hilo.sv
// Channel | Ports                                                       | Dir
// input   | in_valid_i, in_ready_o, command_i, rs_value_i, rt_value_i,  | in
//         | shift_amount_i                                              |
// result  | out_valid_o, out_ready_i, rd_value_o, rd_write_o,           | out
//         | trap_code_o                                                 |
//
// ALU ops and MFHI/MFLO/MTHI/MTLO: transaction in, result in the next cycle.
// Multiply: result transaction in the cycle after the input; once it is taken,
// four 64x16 partial products plus a write-back run on the shared unit before
// the next input. Divide: likewise, with 64 restoring steps plus a write-back.
// Reset clears HI, LO and the controller; the result holds while stalled.
module mips64_special_alu_hilo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [5:0]         command_i,
  input  logic signed [63:0] rs_value_i,
  input  logic signed [63:0] rt_value_i,
  input  logic [4:0]         shift_amount_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [63:0] rd_value_o,
  output logic               rd_write_o,
  output logic [1:0]         trap_code_o
);

  msah_pkg::cmd_t cmd;
  msah_pkg::sts_t sts;
  logic           out_valid;

  // sequencer: idle, present result, then run the mul/div unit if needed
  msah_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // datapath: ALU, HI/LO and the iterative multiply/divide unit
  msah_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .command_i      (command_i),
    .rs_value_i     (rs_value_i),
    .rt_value_i     (rt_value_i),
    .shift_amount_i (shift_amount_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .rd_value_o     (rd_value_o),
    .rd_write_o     (rd_write_o),
    .trap_code_o    (trap_code_o)
  );

  assign out_valid_o = out_valid;

endmodule

### hdl/msah_chk.sv
module msah_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] rd_value_o,
  input logic        rd_write_o,
  input logic [1:0]  trap_code_o
);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("input taken while result pending");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> out_valid_o) else $error("no result after transaction");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(rd_value_o))
    else $error("result dropped");

  a_zero_nowrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !rd_write_o) |-> rd_value_o == 64'd0) else $error("stray rd value");

  a_trap_nowrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && trap_code_o != msah_pkg::TRAP_NONE) |-> !rd_write_o)
    else $error("trap with write");

endmodule

bind mips64_special_alu_hilo msah_chk u_chk (.*);

### test/tb_mips64_special_alu_hilo.sv
module tb_mips64_special_alu_hilo;

  // SYNC has no package constant; an unlisted code acts the same way
  localparam logic [5:0] F_SYNC_NOP = 6'd15;

  // Result transaction as seen on the output channel
  typedef struct {
    logic [63:0] rd;
    logic        wr;
    logic [1:0]  trap;
  } alu_res_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [5:0]         command_i = '0;
  logic signed [63:0] rs_value_i = '0;
  logic signed [63:0] rt_value_i = '0;
  logic [4:0]         shift_amount_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [63:0] rd_value_o;
  logic               rd_write_o;
  logic [1:0]         trap_code_o;

  mips64_special_alu_hilo dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .command_i(command_i), .rs_value_i(rs_value_i), .rt_value_i(rt_value_i),
    .shift_amount_i(shift_amount_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .rd_value_o(rd_value_o), .rd_write_o(rd_write_o), .trap_code_o(trap_code_o)
  );

  always #10 clk_i = ~clk_i;

  // Shadow HI/LO, updated as each instruction is issued
  logic [63:0] hi_q = '0;
  logic [63:0] lo_q = '0;
  alu_res_t    pending_q[$];
  int          mismatches = 0;
  int          n_checked = 0;
  int          n_sent = 0;
  int          cycles = 0;
  int          burst_left = 0;
  localparam int CYCLE_LIMIT = 400000;

  // Codes the unit recognises; others are no-ops
  logic [5:0] known_ops[] = '{
    msah_pkg::F_SLL, msah_pkg::F_SRL, msah_pkg::F_SRA, msah_pkg::F_SLLV,
    msah_pkg::F_SRLV, msah_pkg::F_SRAV, msah_pkg::F_SYSCALL, msah_pkg::F_MFHI,
    msah_pkg::F_MTHI, msah_pkg::F_MFLO, msah_pkg::F_MTLO, msah_pkg::F_DSLLV,
    msah_pkg::F_DSRLV, msah_pkg::F_DSRAV, msah_pkg::F_MULT, msah_pkg::F_MULTU,
    msah_pkg::F_DIV, msah_pkg::F_DIVU, msah_pkg::F_DMULT, msah_pkg::F_DMULTU,
    msah_pkg::F_DDIV, msah_pkg::F_DDIVU, msah_pkg::F_ADD, msah_pkg::F_ADDU,
    msah_pkg::F_SUB, msah_pkg::F_SUBU, msah_pkg::F_AND, msah_pkg::F_OR,
    msah_pkg::F_XOR, msah_pkg::F_NOR, msah_pkg::F_SLT, msah_pkg::F_SLTU,
    msah_pkg::F_DADD, msah_pkg::F_DADDU, msah_pkg::F_DSUB, msah_pkg::F_DSUBU,
    msah_pkg::F_TEQ, msah_pkg::F_DSLL, msah_pkg::F_DSRL, msah_pkg::F_DSRA,
    msah_pkg::F_DSLL32, msah_pkg::F_DSRL32, msah_pkg::F_DSRA32};

  function automatic logic [63:0] sx32(logic [31:0] x);
    return {{32{x[31]}}, x};
  endfunction

  // Works out the rd result and advances HI/LO for one instruction
  function automatic alu_res_t alu_predict(logic [5:0] op, logic [63:0] rs,
                                           logic [63:0] rt, logic [4:0] sa);
    alu_res_t    r;
    logic [31:0] rs32, rt32;
    logic [127:0] p;
    logic signed [63:0] a, b;
    rs32 = rs[31:0];
    rt32 = rt[31:0];
    r.rd = '0;
    r.wr = 1'b1;
    r.trap = msah_pkg::TRAP_NONE;
    case (op)
      msah_pkg::F_SLL:    r.rd = sx32(rt32 << sa);
      msah_pkg::F_SRL:    r.rd = sx32(rt32 >> sa);
      msah_pkg::F_SRA:    r.rd = sx32($signed(rt32) >>> sa);
      msah_pkg::F_SLLV:   r.rd = sx32(rt32 << rs32[4:0]);
      msah_pkg::F_SRLV:   r.rd = sx32(rt32 >> rs32[4:0]);
      msah_pkg::F_SRAV:   r.rd = sx32($signed(rt32) >>> rs32[4:0]);
      msah_pkg::F_SYSCALL: begin r.wr = 1'b0; r.trap = msah_pkg::TRAP_SYS; end
      msah_pkg::F_MFHI:   r.rd = hi_q;
      msah_pkg::F_MTHI:   begin r.wr = 1'b0; hi_q = rs; end
      msah_pkg::F_MFLO:   r.rd = lo_q;
      msah_pkg::F_MTLO:   begin r.wr = 1'b0; lo_q = rs; end
      msah_pkg::F_DSLLV:  r.rd = rt << rs32[5:0];
      msah_pkg::F_DSRLV:  r.rd = rt >> rs32[5:0];
      msah_pkg::F_DSRAV:  r.rd = $signed(rt) >>> rs32[5:0];
      msah_pkg::F_MULT: begin
        r.wr = 1'b0;
        p = $signed(sx32(rs32)) * $signed(sx32(rt32));
        hi_q = sx32(p[63:32]);
        lo_q = sx32(p[31:0]);
      end
      msah_pkg::F_MULTU: begin
        r.wr = 1'b0;
        p = {32'd0, rs32} * {32'd0, rt32};
        hi_q = sx32(p[63:32]);
        lo_q = sx32(p[31:0]);
      end
      msah_pkg::F_DIV: begin
        r.wr = 1'b0;
        if (rt32 != 0) begin
          if (rs32 == 32'h8000_0000 && rt32 == 32'hFFFF_FFFF) begin
            lo_q = sx32(32'h8000_0000);
            hi_q = '0;
          end else begin
            lo_q = sx32($signed(rs32) / $signed(rt32));
            hi_q = sx32($signed(rs32) % $signed(rt32));
          end
        end
      end
      msah_pkg::F_DIVU: begin
        r.wr = 1'b0;
        if (rt32 != 0) begin
          lo_q = sx32(rs32 / rt32);
          hi_q = sx32(rs32 % rt32);
        end
      end
      msah_pkg::F_DMULT: begin
        r.wr = 1'b0;
        p = {{64{rs[63]}}, rs} * {{64{rt[63]}}, rt};
        {hi_q, lo_q} = p;
      end
      msah_pkg::F_DMULTU: begin
        r.wr = 1'b0;
        p = {64'd0, rs} * {64'd0, rt};
        {hi_q, lo_q} = p;
      end
      msah_pkg::F_DDIV: begin
        r.wr = 1'b0;
        if (rt != 0) begin
          if (rs == 64'h8000_0000_0000_0000 && rt == '1) begin
            lo_q = rs;
            hi_q = '0;
          end else begin
            a = rs;
            b = rt;
            lo_q = a / b;
            hi_q = a % b;
          end
        end
      end
      msah_pkg::F_DDIVU: begin
        r.wr = 1'b0;
        if (rt != 0) begin
          lo_q = rs / rt;
          hi_q = rs % rt;
        end
      end
      msah_pkg::F_ADD, msah_pkg::F_ADDU: r.rd = sx32(rs32 + rt32);
      msah_pkg::F_SUB, msah_pkg::F_SUBU: r.rd = sx32(rs32 - rt32);
      msah_pkg::F_AND:    r.rd = rs & rt;
      msah_pkg::F_OR:     r.rd = rs | rt;
      msah_pkg::F_XOR:    r.rd = rs ^ rt;
      msah_pkg::F_NOR:    r.rd = ~(rs | rt);
      msah_pkg::F_SLT:    r.rd = {63'd0, $signed(rs) < $signed(rt)};
      msah_pkg::F_SLTU:   r.rd = {63'd0, rs < rt};
      msah_pkg::F_DADD, msah_pkg::F_DADDU: r.rd = rs + rt;
      msah_pkg::F_DSUB, msah_pkg::F_DSUBU: r.rd = rs - rt;
      msah_pkg::F_TEQ: begin
        r.wr = 1'b0;
        r.trap = (rs == rt) ? msah_pkg::TRAP_TEQ : msah_pkg::TRAP_NONE;
      end
      msah_pkg::F_DSLL:   r.rd = rt << sa;
      msah_pkg::F_DSRL:   r.rd = rt >> sa;
      msah_pkg::F_DSRA:   r.rd = $signed(rt) >>> sa;
      msah_pkg::F_DSLL32: r.rd = rt << (7'd32 + sa);
      msah_pkg::F_DSRL32: r.rd = rt >> (7'd32 + sa);
      msah_pkg::F_DSRA32: r.rd = $signed(rt) >>> (7'd32 + sa);
      default:  r.wr = 1'b0;
    endcase
    return r;
  endfunction

  // Issues one instruction; honours burst/gap idling, waits for the handshake.
  // Valid stays up after the handshake so a burst can follow straight on.
  task automatic issue(logic [5:0] op, logic [63:0] rs, logic [63:0] rt, logic [4:0] sa);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    command_i      <= op;
    rs_value_i     <= rs;
    rt_value_i     <= rt;
    shift_amount_i <= sa;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // accepted on this edge
    pending_q.push_back(alu_predict(op, rs, rt, sa));
    n_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 7))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7FFF_FFFF_FFFF_FFFF;
      2: return '1;
      3: return 64'd0;
      4: return sx32($urandom);
      5: return {32'd0, $urandom};
      6: return {32'd0, $urandom_range(0, 9)};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Result checking against the oldest outstanding prediction
  always @(posedge clk_i) begin
    alu_res_t e;
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction rd=%h", rd_value_o);
      end else begin
        e = pending_q.pop_front();
        n_checked++;
        if (e.rd !== rd_value_o || e.wr !== rd_write_o || e.trap !== trap_code_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: exp rd=%h wr=%b trap=%0d, got rd=%h wr=%b trap=%0d",
                     n_checked, e.rd, e.wr, e.trap, rd_value_o, rd_write_o, trap_code_o);
        end
      end
    end
  end

  // Receiver stall pattern: quiet stretches, then phases of heavy back-pressure
  always @(posedge clk_i) begin
    if ((cycles / 300) % 3 == 0) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(0, 2) != 0);
  end

  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Extreme operands and a selection of ops, including the special cases
  task automatic test_directed();
    issue(msah_pkg::F_MFHI, 0, 0, 0);
    issue(msah_pkg::F_DIV, 64'h8000_0000, '1, 0);           // 32-bit min / -1
    issue(msah_pkg::F_MFLO, 0, 0, 0);
    issue(msah_pkg::F_DDIV, 64'h8000_0000_0000_0000, '1, 0); // 64-bit min / -1
    issue(msah_pkg::F_MFHI, 0, 0, 0);
    issue(msah_pkg::F_DIVU, 5, 64'hFFFF_FFFF_0000_0000, 0);  // low word zero: no change
    issue(msah_pkg::F_DDIV, -7, 2, 0);                        // truncation toward zero
    issue(msah_pkg::F_MFLO, 0, 0, 0);
    issue(msah_pkg::F_MFHI, 0, 0, 0);
    issue(msah_pkg::F_DDIVU, 1, 0, 0);
    issue(msah_pkg::F_MULT, 64'h1_8000_0000, 64'h7FFF_FFFF, 0);
    issue(msah_pkg::F_MFHI, 0, 0, 0);
    issue(msah_pkg::F_DMULT, '1, 64'h8000_0000_0000_0000, 0);
    issue(msah_pkg::F_MFHI, 0, 0, 0);
    issue(msah_pkg::F_SYSCALL, 1, 1, 0);
    issue(msah_pkg::F_TEQ, '1, '1, 0);
    issue(msah_pkg::F_TEQ, '1, 64'h7FFF_FFFF_FFFF_FFFF, 0);
    issue(F_SYNC_NOP, 0, 0, 0);
    issue(msah_pkg::F_DSRA32, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 5'd31);
    issue(msah_pkg::F_SRAV, 64'h1F, 64'h8000_0000, 0);
    issue(msah_pkg::F_DSLLV, 64'h3F, '1, 0);
    issue(msah_pkg::F_SLT, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 0);
    issue(msah_pkg::F_SLTU, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 0);
    issue(msah_pkg::F_ADD, 64'h7FFF_FFFF, 1, 0);
    issue(msah_pkg::F_DSUB, 64'h8000_0000_0000_0000, 1, 0);
  endtask

  // Random instruction mix: mostly recognised ops, some arbitrary codes
  task automatic test_random(int n);
    logic [5:0] op;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) op = 6'($urandom_range(0, 63));
      else op = known_ops[$urandom_range(0, known_ops.size() - 1)];
      issue(op, rand64(), rand64(), 5'($urandom_range(0, 31)));
      if (i == n / 2) drain(); // sender holds off until the pipe is empty
    end
  endtask

  // Moves into HI or LO, each followed straight away by a read of HI or LO
  task automatic test_hilo_moves(int n);
    for (int i = 0; i < n; i++) begin
      issue($urandom_range(0, 1) ? msah_pkg::F_MTHI : msah_pkg::F_MTLO,
            rand64(), rand64(), 0);
      issue($urandom_range(0, 1) ? msah_pkg::F_MFHI : msah_pkg::F_MFLO, 0, 0, 0);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_hilo_moves(20);
    test_random(590);
    drain();
    repeat (100) @(posedge clk_i);
    $display("sent %0d instructions, checked %0d results", n_sent, n_checked);
    $display("covered shifts, add/sub, logic, compares, mul/div with HI/LO, traps");
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
